// File: design/ohs_pkg.sv
// Shared types, constants and the FNV step function for the open addressing hash set.
`default_nettype none
package ohs_pkg;

    localparam int CAPACITY       = 1024;
    localparam int SLOT_W         = $clog2(CAPACITY);
    localparam int CNT_W          = 11;
    localparam int KEY_W          = 64;
    localparam int FILL_W         = 10;
    localparam int MAX_PROBES_DEF = 64;
    localparam int ENTRY_W        = KEY_W + 2;

    localparam logic [FILL_W-1:0] FILL_RESET  = 10'd819;
    localparam logic [KEY_W-1:0]  FNV_BASIS   = 64'hCBF29CE484222325;
    // prime is 2^40 + 0x1B3
    localparam logic [8:0]        FNV_PRIME_LO = 9'h1B3;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_CONTAINS = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_ITERATE  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_PRESENT       = 3'd1,
        ST_NOT_FOUND     = 3'd2,
        ST_FULL          = 3'd3,
        ST_ALREADY_EMPTY = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_DECODE,
        S_HASH_K,
        S_HASH_K_WAIT,
        S_HASH_V_WAIT,
        S_PROBE_CHK,
        S_FINISH,
        S_ITER_RD,
        S_ITER_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic chain;
    } hash_cmd_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [SLOT_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } tbl_req_t;

    function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                  input logic [7:0] b);
        logic [KEY_W-1:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + x * {55'd0, FNV_PRIME_LO};
    endfunction

endpackage
`default_nettype wire

// File: design/ohs_fnv_unit.sv
// FNV-1a hash unit: one byte of the operand per cycle.
`default_nettype none
module ohs_fnv_unit (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ohs_pkg::hash_cmd_t      cmd,
    input  wire logic [ohs_pkg::KEY_W-1:0] operand,
    output logic [ohs_pkg::KEY_W-1:0]    hash,
    output logic                         done
);
    logic [ohs_pkg::KEY_W-1:0] h_reg, h_next;
    logic [ohs_pkg::KEY_W-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    always_comb begin
        h_next    = h_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (cmd.start) begin
            h_next    = cmd.chain ? h_reg : ohs_pkg::FNV_BASIS;
            n_next    = operand;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            h_next = ohs_pkg::fnv_step(h_reg, n_reg[7:0]);
            n_next = n_reg >> 8;
            // stop after the highest nonzero byte, at least one byte
            if (n_reg[ohs_pkg::KEY_W-1:8] == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        h_reg <= h_next;
        n_reg <= n_next;
    end

    assign hash = h_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// File: design/ohs_table.sv
// Slot table: used mark, tombstone mark and key per slot, one port, registered read.
`default_nettype none
module ohs_table (
    input  wire logic                      aclk,
    input  wire ohs_pkg::tbl_req_t         req,
    output logic [ohs_pkg::ENTRY_W-1:0]    rdata
);
    logic [ohs_pkg::ENTRY_W-1:0] mem [ohs_pkg::CAPACITY];
    logic [ohs_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: design/open_addressing_hash_set.sv
// Top level of the open addressing hash set: sequencer, counters and result register.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_opcode, s_value, s_cursor
//  m_      | out       | m_valid / m_ready    | m_status, m_found_value, m_next_cursor,
//          |           |                      | m_live_count, m_tomb_count
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_data (fill_limit)
//
// One item at a time. Each probe hashes the probe number and then the value, byte by byte, in
// the byte-serial FNV unit, and then reads one table slot. Iterate reads and checks each slot
// in turn. Clear, and a remove that empties the set, sweep the table marks at one slot a cycle.
// After reset the same sweep runs with s_ready low; cfg writes are taken at any time. A stalled
// result is held in the output register while the next item is accepted.
`default_nettype none
module open_addressing_hash_set #(
    parameter int MAX_PROBES = ohs_pkg::MAX_PROBES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [63:0] s_value,
    input  wire logic [10:0] s_cursor,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_found_value,
    output logic [10:0]      m_next_cursor,
    output logic [10:0]      m_live_count,
    output logic [10:0]      m_tomb_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);
    localparam int K_W    = $clog2(MAX_PROBES);
    localparam int SLOT_W = ohs_pkg::SLOT_W;
    localparam int CNT_W  = ohs_pkg::CNT_W;
    localparam int KEY_W  = ohs_pkg::KEY_W;
    localparam logic [CNT_W-1:0] CAP   = CNT_W'(ohs_pkg::CAPACITY);
    localparam logic [K_W-1:0]   K_END = K_W'(MAX_PROBES - 1);

    ohs_pkg::state_t  state_reg, state_next;
    ohs_pkg::opcode_t op_reg, op_next;
    logic [KEY_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              have_reg, have_next;
    logic              reuse_reg, reuse_next;
    logic              hitf_reg, hitf_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic [SLOT_W-1:0] hit_reg, hit_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              wdone_reg, wdone_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  tomb_reg, tomb_next;
    logic [9:0]        fill_reg;
    ohs_pkg::status_t  rst_reg, rst_next;
    logic [KEY_W-1:0]  rfound_reg, rfound_next;
    logic [CNT_W-1:0]  rnext_reg, rnext_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [KEY_W-1:0]  m_found_reg, m_found_next;
    logic [CNT_W-1:0]  m_next_reg, m_next_next;
    logic [CNT_W-1:0]  m_live_reg, m_live_next;
    logic [CNT_W-1:0]  m_tomb_reg, m_tomb_next;

    ohs_pkg::hash_cmd_t hcmd;
    logic [KEY_W-1:0]   hoperand;
    logic [KEY_W-1:0]   hash;
    logic               hdone;
    ohs_pkg::tbl_req_t  treq;
    logic [ohs_pkg::ENTRY_W-1:0] trdata;

    logic             e_used, e_tomb;
    logic [KEY_W-1:0] e_key;
    logic [11:0]      occupied;

    ohs_fnv_unit u_fnv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hcmd),
        .operand (hoperand),
        .hash    (hash),
        .done    (hdone)
    );

    ohs_table u_tbl (
        .aclk  (aclk),
        .req   (treq),
        .rdata (trdata)
    );

    assign e_used   = trdata[ohs_pkg::ENTRY_W-1];
    assign e_tomb   = trdata[ohs_pkg::ENTRY_W-2];
    assign e_key    = trdata[KEY_W-1:0];
    assign occupied = {1'b0, live_reg} + {1'b0, tomb_reg};

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        have_next   = have_reg;
        reuse_next  = reuse_reg;
        hitf_next   = hitf_reg;
        free_next   = free_reg;
        hit_next    = hit_reg;
        slot_next   = slot_reg;
        wdone_next  = wdone_reg;
        live_next   = live_reg;
        tomb_next   = tomb_reg;
        rst_next    = rst_reg;
        rfound_next = rfound_reg;
        rnext_next  = rnext_reg;
        hcmd        = '0;
        hoperand    = val_reg;
        treq        = '0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_next_next   = m_next_reg;
        m_live_next   = m_live_reg;
        m_tomb_next   = m_tomb_reg;

        unique case (state_reg)
            ohs_pkg::S_WIPE: begin
                treq.en    = 1'b1;
                treq.we    = 1'b1;
                treq.addr  = idx_reg[SLOT_W-1:0];
                treq.wdata = '0;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == CAP - 1'b1) begin
                    state_next = wdone_reg ? ohs_pkg::S_DONE : ohs_pkg::S_IDLE;
                end
            end
            ohs_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next    = ohs_pkg::opcode_t'(s_opcode);
                    val_next   = s_value;
                    idx_next   = s_cursor;
                    state_next = ohs_pkg::S_DECODE;
                end
            end
            ohs_pkg::S_DECODE: begin
                rst_next    = ohs_pkg::ST_OK;
                rfound_next = '0;
                rnext_next  = '0;
                k_next      = '0;
                have_next   = 1'b0;
                reuse_next  = 1'b0;
                hitf_next   = 1'b0;
                state_next  = ohs_pkg::S_DONE;
                unique case (op_reg)
                    ohs_pkg::OP_INSERT: state_next = ohs_pkg::S_HASH_K;
                    ohs_pkg::OP_CONTAINS, ohs_pkg::OP_REMOVE: begin
                        if (live_reg == '0) begin
                            rst_next = ohs_pkg::ST_NOT_FOUND;
                        end else begin
                            state_next = ohs_pkg::S_HASH_K;
                        end
                    end
                    ohs_pkg::OP_CLEAR: begin
                        if (live_reg != '0 || tomb_reg != '0) begin
                            live_next  = '0;
                            tomb_next  = '0;
                            idx_next   = '0;
                            wdone_next = 1'b1;
                            state_next = ohs_pkg::S_WIPE;
                        end else begin
                            rst_next = ohs_pkg::ST_ALREADY_EMPTY;
                        end
                    end
                    ohs_pkg::OP_ITERATE: begin
                        if (idx_reg >= CAP) begin
                            rst_next   = ohs_pkg::ST_NOT_FOUND;
                            rnext_next = CAP;
                        end else begin
                            state_next = ohs_pkg::S_ITER_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ohs_pkg::S_HASH_K: begin
                hcmd.start = 1'b1;
                hcmd.chain = 1'b0;
                hoperand   = KEY_W'(k_reg);
                state_next = ohs_pkg::S_HASH_K_WAIT;
            end
            ohs_pkg::S_HASH_K_WAIT: begin
                if (hdone) begin
                    hcmd.start = 1'b1;
                    hcmd.chain = 1'b1;
                    hoperand   = val_reg;
                    state_next = ohs_pkg::S_HASH_V_WAIT;
                end
            end
            ohs_pkg::S_HASH_V_WAIT: begin
                if (hdone) begin
                    treq.en    = 1'b1;
                    treq.addr  = hash[SLOT_W-1:0];
                    slot_next  = hash[SLOT_W-1:0];
                    state_next = ohs_pkg::S_PROBE_CHK;
                end
            end
            ohs_pkg::S_PROBE_CHK: begin
                priority if (!e_used) begin
                    if (!have_reg) begin
                        free_next = slot_reg;
                        have_next = 1'b1;
                    end
                    state_next = ohs_pkg::S_FINISH;
                end else if (!e_tomb && e_key == val_reg) begin
                    hitf_next  = 1'b1;
                    hit_next   = slot_reg;
                    state_next = ohs_pkg::S_FINISH;
                end else begin
                    if (e_tomb && !have_reg) begin
                        free_next  = slot_reg;
                        reuse_next = 1'b1;
                        have_next  = 1'b1;
                    end
                    if (k_reg == K_END) begin
                        state_next = ohs_pkg::S_FINISH;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ohs_pkg::S_HASH_K;
                    end
                end
            end
            ohs_pkg::S_FINISH: begin
                state_next = ohs_pkg::S_DONE;
                unique case (op_reg)
                    ohs_pkg::OP_INSERT: begin
                        priority if (hitf_reg) begin
                            rst_next = ohs_pkg::ST_PRESENT;
                        end else if (!have_reg) begin
                            rst_next = ohs_pkg::ST_FULL;
                        end else if (!reuse_reg && occupied >= {2'b00, fill_reg}) begin
                            rst_next = ohs_pkg::ST_FULL;
                        end else begin
                            treq.en    = 1'b1;
                            treq.we    = 1'b1;
                            treq.addr  = free_reg;
                            treq.wdata = {1'b1, 1'b0, val_reg};
                            live_next  = live_reg + 1'b1;
                            if (reuse_reg && tomb_reg != '0) begin
                                tomb_next = tomb_reg - 1'b1;
                            end
                        end
                    end
                    ohs_pkg::OP_CONTAINS: begin
                        if (!hitf_reg) rst_next = ohs_pkg::ST_NOT_FOUND;
                    end
                    default: begin
                        if (!hitf_reg) begin
                            rst_next = ohs_pkg::ST_NOT_FOUND;
                        end else begin
                            treq.en    = 1'b1;
                            treq.we    = 1'b1;
                            treq.addr  = hit_reg;
                            treq.wdata = {1'b1, 1'b1, val_reg};
                            if (live_reg == CNT_W'(1)) begin
                                // last live entry gone: drop all marks
                                live_next  = '0;
                                tomb_next  = '0;
                                idx_next   = '0;
                                wdone_next = 1'b1;
                                state_next = ohs_pkg::S_WIPE;
                            end else begin
                                live_next = live_reg - 1'b1;
                                tomb_next = tomb_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            ohs_pkg::S_ITER_RD: begin
                treq.en    = 1'b1;
                treq.addr  = idx_reg[SLOT_W-1:0];
                state_next = ohs_pkg::S_ITER_CHK;
            end
            ohs_pkg::S_ITER_CHK: begin
                priority if (e_used && !e_tomb) begin
                    rfound_next = e_key;
                    rnext_next  = idx_reg + 1'b1;
                    state_next  = ohs_pkg::S_DONE;
                end else if (idx_reg == CAP - 1'b1) begin
                    rst_next   = ohs_pkg::ST_NOT_FOUND;
                    rnext_next = CAP;
                    state_next = ohs_pkg::S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ohs_pkg::S_ITER_RD;
                end
            end
            ohs_pkg::S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = rst_reg;
                    m_found_next  = rfound_reg;
                    m_next_next   = rnext_reg;
                    m_live_next   = live_reg;
                    m_tomb_next   = tomb_reg;
                    wdone_next    = 1'b0;
                    state_next    = ohs_pkg::S_IDLE;
                end
            end
            default: state_next = ohs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ohs_pkg::S_WIPE;
            idx_reg     <= '0;
            wdone_reg   <= 1'b0;
            live_reg    <= '0;
            tomb_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            wdone_reg   <= wdone_next;
            live_reg    <= live_next;
            tomb_reg    <= tomb_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        have_reg     <= have_next;
        reuse_reg    <= reuse_next;
        hitf_reg     <= hitf_next;
        free_reg     <= free_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        rst_reg      <= rst_next;
        rfound_reg   <= rfound_next;
        rnext_reg    <= rnext_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_next_reg   <= m_next_next;
        m_live_reg   <= m_live_next;
        m_tomb_reg   <= m_tomb_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= ohs_pkg::FILL_RESET;
        end else if (cfg_valid) begin
            fill_reg <= cfg_data;
        end
    end

    assign s_ready       = (state_reg == ohs_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_reg;
    assign m_next_cursor = m_next_reg;
    assign m_live_count  = m_live_reg;
    assign m_tomb_count  = m_tomb_reg;
endmodule
`default_nettype wire

// File: design/ohs_checker.sv
// Port-level checks for the open addressing hash set, bound to the top level.
`default_nettype none
module ohs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [63:0] m_found_value,
    input wire logic [10:0] m_next_cursor,
    input wire logic [10:0] m_live_count,
    input wire logic [10:0] m_tomb_count
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_value))
        else $error("result item changed while stalled");

    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ohs_pkg::ST_OK |-> m_found_value == 64'd0)
        else $error("found value set on a failed operation");

    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_live_count} + {1'b0, m_tomb_count}) <= 12'd1024
                    && m_next_cursor <= 11'd1024)
        else $error("counts or cursor out of range");

    a_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("item taken before the reset sweep finished");
endmodule

bind open_addressing_hash_set ohs_checker u_ohs_checker (.*);
`default_nettype wire
